/* sv/tga_rle24_decoder_assert.svh */
// Assertion macros for the TGA RLE decoder.
`ifndef TGA_RLE24_DECODER_ASSERT_SVH
`define TGA_RLE24_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define TGA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tga decoder assertion failed");
`define TGA_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tga decoder reset assertion failed");
`else
`define TGA_ASSERT(lbl, prop)
`define TGA_ASSERT_RST(lbl, prop)
`endif

`endif

/* sv/tga_pkg.sv */
// Types and constants shared by the TGA RLE decoder modules.
package tga_pkg;

  localparam int unsigned HEADER_LEN  = 18;
  localparam int unsigned PIXEL_BYTES = 3;
  localparam int unsigned QD_DEPTH    = 4;
  localparam int unsigned QD_AW       = $clog2(QD_DEPTH);

  localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
  localparam logic [4:0] HDR_LAST      = 5'(HEADER_LEN - 1);
  localparam logic [1:0] PIX_LAST      = 2'(PIXEL_BYTES - 1);
  localparam logic [6:0] COUNT_MASK    = 7'h7f;

  typedef enum logic [1:0] {
    FR_HEADER,
    FR_HEAD,
    FR_PIXEL
  } tga_front_state_t;

  typedef enum logic {
    BK_IDLE,
    BK_WALK
  } tga_back_state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } tga_in_t;

  typedef struct packed {
    logic [23:0] pixel_value;
    logic [7:0]  repeat_count;
    logic [15:0] column;
    logic [15:0] storage_row;
    logic        last_of_image;
  } tga_out_t;

  typedef struct packed {
    logic        is_start;
    logic [23:0] pixel;
    logic [7:0]  count;
    logic [15:0] img_width;
    logic [15:0] img_height;
  } tga_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tga_qstat_t;

endpackage

/* sv/tga_front.sv */
// Byte parser: header capture, packet heads and pixel assembly.
module tga_front
  import tga_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  tga_in_t    in_data,
  input  tga_qstat_t q_stat,
  output logic       q_push,
  output tga_entry_t q_entry
);

  tga_front_state_t state_r, state_nxt, state_e;
  logic [4:0]  hidx_r, hidx_nxt, hidx_e;
  logic [1:0]  bidx_r, bidx_nxt, bidx_e;
  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic        run_r, run_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [15:0] pix_r, pix_nxt;
  logic        accept;
  logic [7:0]  b;

  assign in_full = q_stat.full;
  assign accept  = in_push && !q_stat.full;
  assign b       = in_data.data_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_HEADER;
      hidx_r  <= '0;
      bidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      hidx_r  <= hidx_nxt;
      bidx_r  <= bidx_nxt;
    end
    width_r  <= width_nxt;
    height_r <= height_nxt;
    run_r    <= run_nxt;
    left_r   <= left_nxt;
    pix_r    <= pix_nxt;
  end

  always_comb begin
    state_e    = in_data.start_of_file ? FR_HEADER : state_r;
    hidx_e     = in_data.start_of_file ? 5'd0 : hidx_r;
    bidx_e     = in_data.start_of_file ? 2'd0 : bidx_r;
    state_nxt  = state_r;
    hidx_nxt   = hidx_r;
    bidx_nxt   = bidx_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    run_nxt    = run_r;
    left_nxt   = left_r;
    pix_nxt    = pix_r;
    q_push     = 1'b0;
    q_entry.is_start   = (state_e == FR_HEADER);
    q_entry.pixel      = {b, pix_r};
    q_entry.count      = run_r ? left_r : 8'd1;
    q_entry.img_width  = width_r;
    q_entry.img_height = height_r;
    if (accept) begin
      case (state_e)
        FR_HEADER: begin
          if (hidx_e == HDR_WIDTH_LO) width_nxt[7:0] = b;
          if (hidx_e == HDR_WIDTH_HI) width_nxt[15:8] = b;
          if (hidx_e == HDR_HEIGHT_LO) height_nxt[7:0] = b;
          if (hidx_e == HDR_HEIGHT_HI) height_nxt[15:8] = b;
          state_nxt = FR_HEADER;
          hidx_nxt  = hidx_e + 5'd1;
          bidx_nxt  = bidx_e;
          if (hidx_e == HDR_LAST) begin
            hidx_nxt  = '0;
            state_nxt = FR_HEAD;
            q_push    = 1'b1;
          end
        end
        FR_HEAD: begin
          run_nxt   = b[7];
          left_nxt  = {1'b0, b[6:0] & COUNT_MASK} + 8'd1;
          bidx_nxt  = '0;
          state_nxt = FR_PIXEL;
        end
        FR_PIXEL: begin
          bidx_nxt = bidx_r + 2'd1;
          if (bidx_r == 2'd0) pix_nxt[7:0] = b;
          if (bidx_r == 2'd1) pix_nxt[15:8] = b;
          if (bidx_r == PIX_LAST) begin
            bidx_nxt = '0;
            q_push   = 1'b1;
            if (run_r) begin
              state_nxt = FR_HEAD;
            end else begin
              left_nxt = left_r - 8'd1;
              if (left_r == 8'd1) state_nxt = FR_HEAD;
            end
          end
        end
        default: begin
          state_nxt = FR_HEADER;
        end
      endcase
    end
  end

endmodule

/* sv/tga_queue.sv */
// Short request queue between the parser and the position walker.
module tga_queue
  import tga_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  tga_entry_t wdata,
  input  logic       pop,
  output tga_entry_t rdata,
  output tga_qstat_t stat
);

  tga_entry_t           mem [QD_DEPTH];
  logic [QD_AW-1:0]     wptr_r, wptr_nxt;
  logic [QD_AW-1:0]     rptr_r, rptr_nxt;
  logic [QD_AW:0]       cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign stat.full  = (cnt_r == (QD_AW+1)'(QD_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem[rptr_r];

  always_comb begin
    wptr_nxt = do_push ? wptr_r + QD_AW'(1) : wptr_r;
    rptr_nxt = do_pop ? rptr_r + QD_AW'(1) : rptr_r;
    cnt_nxt  = cnt_r + (QD_AW+1)'(do_push) - (QD_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr_r] <= wdata;
  end

endmodule

/* sv/tga_back.sv */
// Position walker: clamps runs to the image and places each result.
`include "tga_rle24_decoder_assert.svh"
module tga_back
  import tga_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  tga_entry_t q_entry,
  input  tga_qstat_t q_stat,
  output logic       q_pop,
  output logic       out_empty,
  input  logic       out_pop,
  output tga_out_t   out_data
);

  tga_back_state_t state_r, state_nxt;
  logic        done_r, done_nxt;
  logic        out_valid_r, out_valid_nxt;
  tga_out_t    out_r, out_nxt;
  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic [15:0] col_r, col_nxt;
  logic [15:0] row_r, row_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [7:0]  cov_r, cov_nxt;
  logic [23:0] pix_r, pix_nxt;
  logic [15:0] scol_r, scol_nxt;
  logic [15:0] srow_r, srow_nxt;
  logic [15:0] space;
  logic [16:0] newcol;
  logic [15:0] row_inc;
  logic        fits, finish, last, out_free;
  logic [7:0]  cov_fin;

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      done_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r    <= out_nxt;
    width_r  <= width_nxt;
    height_r <= height_nxt;
    col_r    <= col_nxt;
    row_r    <= row_nxt;
    left_r   <= left_nxt;
    cov_r    <= cov_nxt;
    pix_r    <= pix_nxt;
    scol_r   <= scol_nxt;
    srow_r   <= srow_nxt;
  end

  always_comb begin
    space   = width_r - col_r;
    newcol  = {1'b0, col_r} + {9'd0, left_r};
    row_inc = row_r + 16'd1;
    fits    = ({8'd0, left_r} <= space);
    finish  = 1'b0;
    last    = 1'b0;
    cov_fin = cov_r + left_r;
    if (fits) begin
      finish = 1'b1;
      last   = (newcol == {1'b0, width_r}) && (row_inc == height_r);
    end else if (row_inc == height_r) begin
      finish  = 1'b1;
      last    = 1'b1;
      cov_fin = cov_r + space[7:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    done_nxt      = done_r;
    out_valid_nxt = out_pop ? 1'b0 : out_valid_r;
    out_nxt       = out_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    left_nxt      = left_r;
    cov_nxt       = cov_r;
    pix_nxt       = pix_r;
    scol_nxt      = scol_r;
    srow_nxt      = srow_r;
    q_pop         = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          q_pop = 1'b1;
          if (q_entry.is_start) begin
            width_nxt  = q_entry.img_width;
            height_nxt = q_entry.img_height;
            col_nxt    = '0;
            row_nxt    = '0;
            done_nxt   = (q_entry.img_width == '0) || (q_entry.img_height == '0);
          end else if (!done_r) begin
            pix_nxt   = q_entry.pixel;
            left_nxt  = q_entry.count;
            cov_nxt   = '0;
            scol_nxt  = col_r;
            srow_nxt  = height_r - 16'd1 - row_r;
            state_nxt = BK_WALK;
          end
        end
      end
      BK_WALK: begin
        if (!finish) begin
          cov_nxt  = cov_r + space[7:0];
          left_nxt = left_r - space[7:0];
          col_nxt  = '0;
          row_nxt  = row_inc;
        end else if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_nxt.pixel_value   = pix_r;
          out_nxt.repeat_count  = cov_fin;
          out_nxt.column        = scol_r;
          out_nxt.storage_row   = srow_r;
          out_nxt.last_of_image = last;
          done_nxt              = last;
          state_nxt             = BK_IDLE;
          if (fits && newcol != {1'b0, width_r}) begin
            col_nxt = newcol[15:0];
          end else begin
            col_nxt = '0;
            row_nxt = row_inc;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  `TGA_ASSERT(a_count_nonzero, out_valid_r |-> (out_r.repeat_count != 8'd0))
  `TGA_ASSERT(a_walk_col, (state_r == BK_WALK) |-> (col_r < width_r))
  `TGA_ASSERT(a_walk_row, (state_r == BK_WALK) |-> (row_r < height_r && left_r != 8'd0))
  `TGA_ASSERT(a_last_done, (out_valid_nxt && !out_valid_r && out_nxt.last_of_image) |=> done_r)
  `TGA_ASSERT_RST(a_reset_idle, !rst_n |=> (state_r == BK_IDLE && !out_valid_r && done_r))

endmodule

/* sv/tga_rle24_decoder.sv */
// Top level of the 24-bit run-length TGA decoder.
//
//   port group   dir  handshake        payload
//   in_*         in   in_push/in_full  tga_in_t  (data_byte, start_of_file)
//   out_*        out  out_pop/out_empty tga_out_t (pixel, count, column, row, last)
//
// One byte is taken per cycle while the request queue (four entries) has room.
// Each pixel result keeps the position walker busy for its pop, for each row end
// the run crosses and for placing it, so long runs in narrow images fill the queue and raise in_full.
// A finished result waits in the output register while later bytes are taken.
// Reset is synchronous; there is no clearing pass.
module tga_rle24_decoder
  import tga_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  tga_in_t  in_data,
  output logic     out_empty,
  input  logic     out_pop,
  output tga_out_t out_data
);

  tga_qstat_t q_stat;
  tga_entry_t q_wdata, q_rdata;
  logic       q_push, q_pop;

  tga_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_entry (q_wdata)
  );

  tga_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  tga_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_entry   (q_rdata),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
